// ===== hw/rtl/hrlt_pkg.sv =====
// Package for the hex range line totalizer.
// Holds the byte token, the region event and the scanner phase types.
// Used by every module of the block; depends on nothing.
package hrlt_pkg;

  // Character codes the scanner reacts to.
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_F   = 8'h66;

  // Width of the hex values and of the running total.
  localparam int unsigned VAL_W = 64;
  // Right shift that turns bytes into kilobytes.
  localparam int unsigned KB_SHIFT = 10;
  // Width of the region count port.
  localparam int unsigned CNT_OUT_W = 16;

  // Depth of the queue between classifier and scanner.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One classified input word.
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_dash;
    logic       is_newline;
    logic       is_nul;
    logic       last;
  } token_t;

  // One word from the scanner to the accumulator.
  typedef struct packed {
    logic             close;
    logic             last;
    logic [VAL_W-1:0] start_val;
    logic [VAL_W-1:0] end_val;
  } region_ev_t;

  // Scanner phase, one-hot.
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_END   = 3'b010,
    PH_SKIP  = 3'b100
  } phase_t;

endpackage

// ===== hw/rtl/hrlt_front.sv =====
// Front end of the hex range line totalizer.
// Classifies each incoming byte into a token for the queue.
// Depends on hrlt_pkg.
module hrlt_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic            q_full,
  output logic            q_push,
  output hrlt_pkg::token_t q_tok
);

  logic dec_digit;
  logic hex_letter;

  // Hex digit detection: 0-9 and lowercase a-f only.
  assign dec_digit  = (in_data_byte >= hrlt_pkg::CHAR_ZERO) &&
                      (in_data_byte <= hrlt_pkg::CHAR_NINE);
  assign hex_letter = (in_data_byte >= hrlt_pkg::CHAR_LOW_A) &&
                      (in_data_byte <= hrlt_pkg::CHAR_LOW_F);

  // Build the token from the byte.
  always_comb begin
    q_tok.is_digit   = dec_digit || hex_letter;
    q_tok.digit      = dec_digit ? in_data_byte[3:0] : (in_data_byte[3:0] + 4'd9);
    q_tok.is_dash    = (in_data_byte == hrlt_pkg::CHAR_DASH);
    q_tok.is_newline = (in_data_byte == hrlt_pkg::CHAR_NEWLINE);
    q_tok.is_nul     = (in_data_byte == hrlt_pkg::CHAR_NUL);
    q_tok.last       = in_last_byte;
  end

  // A word is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/hrlt_queue.sv =====
// Token queue between the classifier and the scanner.
// Small register FIFO with a registered occupancy count.
// Depends on hrlt_pkg.
module hrlt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hrlt_pkg::token_t push_tok,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output hrlt_pkg::token_t head_tok
);

  hrlt_pkg::token_t                  slot_r [hrlt_pkg::QDEPTH];
  logic [hrlt_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [hrlt_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [hrlt_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == hrlt_pkg::QCNT_W'(hrlt_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_tok   = slot_r[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== hw/rtl/hrlt_scan.sv =====
// Line scanner of the hex range line totalizer.
// Parses start-dash-end per line and emits region events.
// Depends on hrlt_pkg.
module hrlt_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tok_valid,
  input  hrlt_pkg::token_t     tok,
  output logic                 tok_pop,
  output logic                 ev_valid,
  output hrlt_pkg::region_ev_t ev,
  input  logic                 ev_ready
);

  hrlt_pkg::phase_t                phase_r, phase_nxt;
  logic [hrlt_pkg::VAL_W-1:0]      start_r, start_nxt;
  logic [hrlt_pkg::VAL_W-1:0]      end_r, end_nxt;
  logic                            stopped_r, stopped_nxt;
  logic                            ev_valid_r, ev_valid_nxt;
  hrlt_pkg::region_ev_t            ev_r, ev_nxt;
  hrlt_pkg::phase_t                ph;
  logic [hrlt_pkg::VAL_W-1:0]      sv;
  logic [hrlt_pkg::VAL_W-1:0]      evl;
  logic                            stp;
  logic                            line_done;
  logic                            scan_close;
  logic                            last_close;
  logic                            s_ready;

  assign s_ready  = !ev_valid_r || ev_ready;
  assign tok_pop  = tok_valid && s_ready;
  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

  // Per-byte parse step.
  always_comb begin
    ph         = phase_r;
    sv         = start_r;
    evl        = end_r;
    stp        = stopped_r;
    line_done  = 1'b0;
    scan_close = 1'b0;
    if (!stopped_r) begin
      unique case (phase_r)
        hrlt_pkg::PH_START: begin
          if (tok.is_digit) begin
            sv = {start_r[hrlt_pkg::VAL_W-5:0], tok.digit};
          end else if (tok.is_dash) begin
            ph  = hrlt_pkg::PH_END;
            evl = '0;
          end else begin
            line_done = 1'b1;
          end
        end
        hrlt_pkg::PH_END: begin
          if (tok.is_digit) begin
            evl = {end_r[hrlt_pkg::VAL_W-5:0], tok.digit};
          end else begin
            scan_close = 1'b1;
            line_done  = 1'b1;
          end
        end
        default: begin
          if (tok.is_newline || tok.is_nul) begin
            line_done = 1'b1;
          end
        end
      endcase
    end
    // End of the useful part of a line.
    if (line_done) begin
      if (tok.is_newline) begin
        ph  = hrlt_pkg::PH_START;
        sv  = '0;
        evl = '0;
      end else if (tok.is_nul) begin
        stp = 1'b1;
      end else begin
        ph = hrlt_pkg::PH_SKIP;
      end
    end
    // An open end run is closed by the end of the stream.
    last_close = tok.last && !stp && (ph == hrlt_pkg::PH_END);
  end

  // State and event register update.
  always_comb begin
    phase_nxt    = phase_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    stopped_nxt  = stopped_r;
    ev_valid_nxt = ev_valid_r;
    ev_nxt       = ev_r;
    if (s_ready) begin
      ev_valid_nxt = 1'b0;
    end
    if (tok_pop) begin
      ev_valid_nxt     = scan_close || last_close || tok.last;
      ev_nxt.close     = scan_close || last_close;
      ev_nxt.last      = tok.last;
      ev_nxt.start_val = scan_close ? start_r : sv;
      ev_nxt.end_val   = scan_close ? end_r : evl;
      if (tok.last) begin
        phase_nxt   = hrlt_pkg::PH_START;
        start_nxt   = '0;
        end_nxt     = '0;
        stopped_nxt = 1'b0;
      end else begin
        phase_nxt   = ph;
        start_nxt   = sv;
        end_nxt     = evl;
        stopped_nxt = stp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= hrlt_pkg::PH_START;
      start_r    <= '0;
      end_r      <= '0;
      stopped_r  <= 1'b0;
      ev_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      start_r    <= start_nxt;
      end_r      <= end_nxt;
      stopped_r  <= stopped_nxt;
      ev_valid_r <= ev_valid_nxt;
    end
  end

  // Event payload needs no reset.
  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

endmodule

// ===== hw/rtl/hrlt_accum.sv =====
// Back end of the hex range line totalizer.
// Takes region differences, keeps the running totals and holds the result word.
// Depends on hrlt_pkg.
module hrlt_accum #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ev_valid,
  input  hrlt_pkg::region_ev_t          ev,
  output logic                          ev_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hrlt_pkg::VAL_W-1:0]    out_total_bytes,
  output logic [hrlt_pkg::VAL_W-hrlt_pkg::KB_SHIFT-1:0] out_total_kb,
  output logic [hrlt_pkg::CNT_OUT_W-1:0] out_region_count
);

  localparam logic [COUNT_WIDTH-1:0] CNT_CAP = '1;

  logic                            d_valid_r, d_valid_nxt;
  logic                            d_gt_r;
  logic                            d_last_r;
  logic [hrlt_pkg::VAL_W-1:0]      d_diff_r;
  logic [hrlt_pkg::VAL_W:0]        sub;
  logic                            gt;
  logic                            d_take;
  logic [hrlt_pkg::VAL_W-1:0]      total_r, total_nxt, total_sum;
  logic [COUNT_WIDTH-1:0]          cnt_r, cnt_nxt, cnt_sum;
  logic [COUNT_WIDTH+hrlt_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic                            out_valid_r, out_valid_nxt;
  logic [hrlt_pkg::VAL_W-1:0]      out_total_r;
  logic [hrlt_pkg::CNT_OUT_W-1:0]  out_cnt_r;

  // Difference stage: end minus start, borrow tells the order.
  assign sub = {1'b0, ev.end_val} - {1'b0, ev.start_val};
  assign gt  = ev.close && !sub[hrlt_pkg::VAL_W] && (sub[hrlt_pkg::VAL_W-1:0] != '0);

  // A last word can only leave when the result register is free.
  assign d_take   = d_valid_r && !(d_last_r && out_valid_r && out_stall);
  assign ev_ready = !d_valid_r || d_take;

  always_comb begin
    d_valid_nxt = d_valid_r;
    if (ev_ready) begin
      d_valid_nxt = ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= d_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev_valid) begin
      d_gt_r   <= gt;
      d_last_r <= ev.last;
      d_diff_r <= sub[hrlt_pkg::VAL_W-1:0];
    end
  end

  // Accumulate stage with a saturating region count.
  assign total_sum = total_r + (d_gt_r ? d_diff_r : '0);
  assign cnt_sum   = (d_gt_r && (cnt_r != CNT_CAP)) ? cnt_r + 1'b1 : cnt_r;
  assign cnt_ext   = {{hrlt_pkg::CNT_OUT_W{1'b0}}, cnt_sum};

  always_comb begin
    total_nxt     = total_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (d_take) begin
      if (d_last_r) begin
        total_nxt     = '0;
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        total_nxt = total_sum;
        cnt_nxt   = cnt_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (d_take && d_last_r) begin
      out_total_r <= total_sum;
      out_cnt_r   <= cnt_ext[hrlt_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_total_bytes  = out_total_r;
  assign out_total_kb     = out_total_r[hrlt_pkg::VAL_W-1:hrlt_pkg::KB_SHIFT];
  assign out_region_count = out_cnt_r;

endmodule

// ===== hw/rtl/hex_range_line_totalizer.sv =====
// Hex range line totalizer, top level. Depends on hrlt_pkg and the hrlt modules.
// Throughput: one byte word per cycle while in_stall is low; out_stall can hold the stages and the queue.
// After the last byte is taken, the result word passes through the queue, the scanner
// register and the difference register, then reaches the result register.
// Reset (rst_n low, synchronous) clears the scan state, the totals and the queue.
module hex_range_line_totalizer #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_total_bytes,
  output logic [53:0] out_total_kb,
  output logic [15:0] out_region_count
);

  logic                 q_full;
  logic                 q_push;
  hrlt_pkg::token_t     q_tok;
  logic                 q_pop;
  logic                 head_valid;
  hrlt_pkg::token_t     head_tok;
  logic                 ev_valid;
  logic                 ev_ready;
  hrlt_pkg::region_ev_t ev;

  // Byte classification.
  hrlt_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tok        (q_tok)
  );

  // Decoupling queue.
  hrlt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (q_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  // Line parsing.
  hrlt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (head_valid),
    .tok       (head_tok),
    .tok_pop   (q_pop),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .ev_ready  (ev_ready)
  );

  // Totals and result word.
  hrlt_accum #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .ev_valid         (ev_valid),
    .ev               (ev),
    .ev_ready         (ev_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_bytes  (out_total_bytes),
    .out_total_kb     (out_total_kb),
    .out_region_count (out_region_count)
  );

endmodule
